>>> hdl/rpwu_pkg.sv
// Shared types and constants for the resilient-propagation weight update block.
package rpwu_pkg;

   localparam int unsigned RPWU_NUM_PARAMS = 1024;

   localparam int unsigned IDX_W  = 10;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned ETA_W  = 16;
   localparam int unsigned ETA_FRAC = 14;
   localparam int unsigned PROD_W = DATA_W + ETA_W;
   localparam int unsigned CSR_IDX_W = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ETA_PLUS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ETA_MINUS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MAX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_INIT = 3'd4;

   localparam logic [ETA_W-1:0]  ETA_PLUS_RST  = 16'd19661;
   localparam logic [ETA_W-1:0]  ETA_MINUS_RST = 16'd8192;
   localparam logic [DATA_W-1:0] STEP_MAX_RST  = 32'd3276800;
   localparam logic [DATA_W-1:0] STEP_MIN_RST  = 32'd1;
   localparam logic [DATA_W-1:0] STEP_INIT_RST = 32'd6554;

   // Kept gradient sign codes.
   localparam logic [1:0] SIGN_ZERO = 2'd0;
   localparam logic [1:0] SIGN_POS  = 2'd1;
   localparam logic [1:0] SIGN_NEG  = 2'd3;

   typedef enum logic [1:0] {
      UPD_HOLD,
      UPD_GROW,
      UPD_SHRINK
   } upd_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        sign;
      logic [DATA_W-1:0] step;
   } entry_type;

endpackage

>>> hdl/rprop_weight_update.sv
// Top level: iRprop- weight update with per-index step and sign kept in one memory.
// Path: an accepted item moves through stage 1, stage 2, stage 3 and the output register.
// Throughput: one item per cycle while the output is not stalled; an item whose index
//   equals that of the item accepted just before it waits until that item leaves
//   stage 1; the wait comes from the step recurrence (memory read, multiply, cap/floor, write back).
// Reset: synchronous; after reset a clearing pass walks every memory entry, marks it
//   invalid and holds req_ready low; configuration writes still apply.
module rprop_weight_update
   import rpwu_pkg::*;
#(
   parameter int unsigned NUM_PARAMS = RPWU_NUM_PARAMS
) (
   input  logic                     clock,
   input  logic                     reset,
   // input beats
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [IDX_W-1:0]         req_param_index,
   input  logic signed [DATA_W-1:0] req_gradient,
   input  logic signed [DATA_W-1:0] req_weight,
   // result beats
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_new_weight,
   // configuration writes
   input  logic                     csr_wen,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   localparam int unsigned AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PARAMS - 1);

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [ETA_W-1:0]  eta_plus_ff, eta_minus_ff;
   logic [DATA_W-1:0] step_max_ff, step_min_ff, step_init_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_plus_ff  <= ETA_PLUS_RST;
         eta_minus_ff <= ETA_MINUS_RST;
         step_max_ff  <= STEP_MAX_RST;
         step_min_ff  <= STEP_MIN_RST;
         step_init_ff <= STEP_INIT_RST;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_ETA_PLUS:  eta_plus_ff  <= csr_wdata[ETA_W-1:0];
            CSR_ETA_MINUS: eta_minus_ff <= csr_wdata[ETA_W-1:0];
            CSR_STEP_MAX:  step_max_ff  <= csr_wdata;
            CSR_STEP_MIN:  step_min_ff  <= csr_wdata;
            CSR_STEP_INIT: step_init_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Clearing pass: walk the memory once after reset and mark entries invalid.
   // ---------------------------------------------------------------------------
   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline control. All stages move together; they hold only while a result
   // sits in the output register and the consumer does not take it.
   // ---------------------------------------------------------------------------
   logic advance;
   logic accept;
   logic [AW-1:0] req_addr;
   logic          req_in_range;

   // stage 1: memory data arrives, pick the step, multiply
   logic                     s1_valid_ff;
   logic [AW-1:0]            s1_addr_ff;
   logic                     s1_in_range_ff;
   logic [DATA_W-1:0]        s1_grad_ff;
   logic signed [DATA_W-1:0] s1_weight_ff;
   entry_type                rd_ff;

   // stage 2: scale, cap or floor, write back
   logic                     s2_valid_ff;
   logic [AW-1:0]            s2_addr_ff;
   logic                     s2_in_range_ff;
   upd_type                  s2_upd_ff;
   logic [PROD_W-1:0]        s2_prod_ff;
   logic [DATA_W-1:0]        s2_step_ff;
   logic [1:0]               s2_gcode_ff;
   logic signed [DATA_W-1:0] s2_weight_ff;

   // stage 3: move the weight and saturate
   logic                     s3_valid_ff;
   logic [AW-1:0]            s3_addr_ff;
   logic                     s3_in_range_ff;
   upd_type                  s3_upd_ff;
   logic [DATA_W-1:0]        s3_step_ff;
   logic [1:0]               s3_sign_ff;
   logic                     s3_gneg_ff;
   logic signed [DATA_W-1:0] s3_weight_ff;

   // output register
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_weight_ff;

   assign advance      = !rsp_valid_ff || rsp_ready;
   assign req_in_range = 32'(req_param_index) < NUM_PARAMS;
   // Out-of-range items read a harmless entry; their result ignores it.
   assign req_addr     = req_in_range ? AW'(req_param_index) : '0;

   // Interlock: the item in stage 1 has not yet written its step back and its
   // new step is not ready for forwarding, so hold a same-index follower.
   assign req_ready = advance && !clr_active_ff &&
                      !(s1_valid_ff && s1_in_range_ff && req_in_range &&
                        s1_addr_ff == req_addr);
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------------------
   // State memory: valid, kept sign and step of every index.
   // ---------------------------------------------------------------------------
   entry_type     mem_ram [NUM_PARAMS];
   logic          mem_wen;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   entry_type     wb_entry;
   logic [DATA_W-1:0] s2_step_in;
   logic [1:0]        s2_sign_in;

   assign wb_entry = '{valid: 1'b1, sign: s2_sign_in, step: s2_step_in};

   always_comb begin
      if (clr_active_ff) begin
         mem_wen   = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '{valid: 1'b0, sign: SIGN_ZERO, step: '0};
      end else begin
         mem_wen   = advance && s2_valid_ff && s2_in_range_ff;
         mem_waddr = s2_addr_ff;
         mem_wdata = wb_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wen) begin
         mem_ram[mem_waddr] <= mem_wdata;
      end
      if (advance) begin
         rd_ff <= mem_ram[req_addr];
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1
   // ---------------------------------------------------------------------------
   entry_type         s1_entry;
   logic              s1_fwd;
   logic [DATA_W-1:0] s1_step;
   logic              s1_gneg, s1_gzero;
   logic              kept_pos, kept_neg;
   upd_type           s1_upd;
   logic [ETA_W-1:0]  s1_eta;
   logic [PROD_W-1:0] s1_prod;
   logic [1:0]        s1_gcode;

   // Forward the entry written by the item two ahead: its write and this
   // item's read landed on the same edge.
   assign s1_fwd = s3_valid_ff && s3_in_range_ff && s3_addr_ff == s1_addr_ff;

   always_comb begin
      s1_entry = s1_fwd ? entry_type'{valid: 1'b1, sign: s3_sign_ff, step: s3_step_ff}
                        : rd_ff;
      s1_gneg  = s1_grad_ff[DATA_W-1];
      s1_gzero = s1_grad_ff == '0;
      s1_gcode = s1_gneg ? SIGN_NEG : (s1_gzero ? SIGN_ZERO : SIGN_POS);
      kept_pos = 1'b0;
      kept_neg = 1'b0;
      if (s1_entry.valid) begin
         s1_step = s1_entry.step;
         case (s1_entry.sign)
            SIGN_POS: kept_pos = 1'b1;
            SIGN_NEG: kept_neg = 1'b1;
            default: ;
         endcase
      end else begin
         s1_step = step_init_ff;
      end
      // A zero gradient makes the sign product zero whatever is kept.
      if (s1_gzero || (!kept_pos && !kept_neg)) begin
         s1_upd = UPD_HOLD;
      end else if ((kept_neg && s1_gneg) || (kept_pos && !s1_gneg)) begin
         s1_upd = UPD_GROW;
      end else begin
         s1_upd = UPD_SHRINK;
      end
      s1_eta  = (s1_upd == UPD_GROW) ? eta_plus_ff : eta_minus_ff;
      s1_prod = PROD_W'(s1_step) * PROD_W'(s1_eta);
   end

   // ---------------------------------------------------------------------------
   // Stage 2
   // ---------------------------------------------------------------------------
   logic [PROD_W-ETA_FRAC-1:0] s2_shift;
   logic [DATA_W-1:0]          s2_scaled;

   always_comb begin
      s2_shift  = s2_prod_ff[PROD_W-1:ETA_FRAC];
      s2_scaled = (|s2_shift[PROD_W-ETA_FRAC-1:DATA_W]) ? '1 : s2_shift[DATA_W-1:0];
      case (s2_upd_ff)
         UPD_GROW: begin
            s2_step_in = (s2_scaled > step_max_ff) ? step_max_ff : s2_scaled;
            s2_sign_in = s2_gcode_ff;
         end
         UPD_SHRINK: begin
            s2_step_in = (s2_scaled < step_min_ff) ? step_min_ff : s2_scaled;
            s2_sign_in = SIGN_ZERO;
         end
         default: begin
            s2_step_in = s2_step_ff;
            s2_sign_in = s2_gcode_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Stage 3
   // ---------------------------------------------------------------------------
   logic signed [DATA_W+1:0] s3_sum;
   logic signed [DATA_W-1:0] rsp_weight_in;

   always_comb begin
      s3_sum = s3_gneg_ff ? (DATA_W+2)'(s3_weight_ff) + $signed({2'b00, s3_step_ff})
                          : (DATA_W+2)'(s3_weight_ff) - $signed({2'b00, s3_step_ff});
      if (!s3_in_range_ff || s3_upd_ff == UPD_SHRINK) begin
         rsp_weight_in = s3_weight_ff;
      end else if (s3_sum[DATA_W+1:DATA_W-1] == 3'b000 ||
                   s3_sum[DATA_W+1:DATA_W-1] == 3'b111) begin
         rsp_weight_in = s3_sum[DATA_W-1:0];
      end else if (!s3_sum[DATA_W+1]) begin
         rsp_weight_in = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         rsp_weight_in = {1'b1, {(DATA_W-1){1'b0}}};
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_addr_ff     <= req_addr;
         s1_in_range_ff <= req_in_range;
         s1_grad_ff     <= req_gradient;
         s1_weight_ff   <= req_weight;

         s2_addr_ff     <= s1_addr_ff;
         s2_in_range_ff <= s1_in_range_ff;
         s2_upd_ff      <= s1_upd;
         s2_prod_ff     <= s1_prod;
         s2_step_ff     <= s1_step;
         s2_gcode_ff    <= s1_gcode;
         s2_weight_ff   <= s1_weight_ff;

         s3_addr_ff     <= s2_addr_ff;
         s3_in_range_ff <= s2_in_range_ff;
         s3_upd_ff      <= s2_upd_ff;
         s3_step_ff     <= s2_step_in;
         s3_sign_ff     <= s2_sign_in;
         s3_gneg_ff     <= s2_gcode_ff == SIGN_NEG;
         s3_weight_ff   <= s2_weight_ff;

         rsp_weight_ff  <= rsp_weight_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_weight = rsp_weight_ff;

endmodule

>>> hdl/rpwu_checker.sv
// Port-level checker for the weight update block, with its bind statement.
module rpwu_checker
   import rpwu_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [IDX_W-1:0]         req_param_index,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_new_weight
);

   // Show no result and hold off input as the clearing pass begins after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_ready))
      else $error("output valid or input ready right after reset");

   // Hold a result until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_new_weight)))
      else $error("result dropped or changed while stalled");

   // Two beats on the same index never land on consecutive edges.
   a_same_index_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=>
         !(req_valid && req_ready && req_param_index == $past(req_param_index)))
      else $error("same index accepted on consecutive edges");

   // Hold off input while a result waits to be taken.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input ready while a result is stalled");

endmodule

bind rprop_weight_update rpwu_checker u_rpwu_checker (.*);

>>> dv/tb_rprop_weight_update.sv
// Self-checking testbench for the iRprop- weight update block, with a built-in update predictor.
module tb_rprop_weight_update;
   timeunit 1ns;
   timeprecision 1ps;
   import rpwu_pkg::*;

   // Cycles to let pass after the last result before touching registers or ending.
   localparam int PIPE_SLACK = 4;
   localparam int HOT_COUNT  = 8;

   localparam logic signed [DATA_W-1:0] W_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] W_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] ONE      = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] MINUS1   = -32'sh0001_0000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [IDX_W-1:0]         req_param_index = '0;
   logic signed [DATA_W-1:0] req_gradient = '0;
   logic signed [DATA_W-1:0] req_weight = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b1;
   logic signed [DATA_W-1:0] rsp_new_weight;
   logic                     csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;

   // Predictor copy of the registers, starting from their reset values.
   logic [ETA_W-1:0]  eta_grow   = ETA_PLUS_RST;
   logic [ETA_W-1:0]  eta_shrink = ETA_MINUS_RST;
   logic [DATA_W-1:0] step_cap   = STEP_MAX_RST;
   logic [DATA_W-1:0] step_floor = STEP_MIN_RST;
   logic [DATA_W-1:0] step_start = STEP_INIT_RST;

   // Predictor copy of the per-index state; a dead entry reads as step_start, zero sign.
   logic [DATA_W-1:0] step_mem [RPWU_NUM_PARAMS];
   logic [1:0]        sign_mem [RPWU_NUM_PARAMS];
   bit                entry_live [RPWU_NUM_PARAMS];

   // New weights still owed by the block, oldest first.
   logic signed [DATA_W-1:0] new_weight_q [$];

   // Indexes that the random traffic keeps revisiting, each with its current gradient sign.
   logic [IDX_W-1:0] hot_idx [HOT_COUNT];
   bit               hot_neg [HOT_COUNT];

   bit idle_on    = 1'b0;
   int stall_left = 0;
   int fail_cnt   = 0;

   rprop_weight_update DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_param_index (req_param_index),
      .req_gradient    (req_gradient),
      .req_weight      (req_weight),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_new_weight  (rsp_new_weight),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Work out the new weight of one accepted beat and advance the predicted state.
   function automatic logic signed [DATA_W-1:0] predict_weight(
      input logic [IDX_W-1:0] idx,
      input logic signed [DATA_W-1:0] grad,
      input logic signed [DATA_W-1:0] w);
      logic [DATA_W-1:0]        step;
      logic [1:0]               kept;
      logic [1:0]               grad_code;
      logic [PROD_W-1:0]        prod;
      logic signed [DATA_W+1:0] w_ext;
      logic signed [DATA_W+1:0] step_ext;
      logic signed [DATA_W+1:0] moved;
      logic signed [DATA_W-1:0] result;
      upd_type                  kind;

      grad_code = grad[DATA_W-1] ? SIGN_NEG : (grad == '0 ? SIGN_ZERO : SIGN_POS);
      step = entry_live[idx] ? step_mem[idx] : step_start;
      kept = entry_live[idx] ? sign_mem[idx] : SIGN_ZERO;

      // Same nonzero sign grows, opposite nonzero sign shrinks, anything zero holds.
      if (grad_code == SIGN_ZERO || (kept != SIGN_POS && kept != SIGN_NEG))
         kind = UPD_HOLD;
      else if (kept == grad_code)
         kind = UPD_GROW;
      else
         kind = UPD_SHRINK;

      case (kind)
         UPD_GROW: begin
            prod = (PROD_W'(step) * PROD_W'(eta_grow)) >> ETA_FRAC;
            step = (prod[PROD_W-1:DATA_W] != '0) ? '1 : prod[DATA_W-1:0];
            if (step > step_cap) step = step_cap;
         end
         UPD_SHRINK: begin
            prod = (PROD_W'(step) * PROD_W'(eta_shrink)) >> ETA_FRAC;
            step = (prod[PROD_W-1:DATA_W] != '0) ? '1 : prod[DATA_W-1:0];
            if (step < step_floor) step = step_floor;
         end
         default: ;
      endcase

      if (kind == UPD_SHRINK) begin
         result = w;
      end else begin
         // Move against the gradient sign (zero counts as positive), then saturate.
         w_ext    = (DATA_W+2)'(w);
         step_ext = {2'b00, step};
         moved    = grad[DATA_W-1] ? w_ext + step_ext : w_ext - step_ext;
         if (moved[DATA_W+1:DATA_W-1] == 3'b000 || moved[DATA_W+1:DATA_W-1] == 3'b111)
            result = moved[DATA_W-1:0];
         else
            result = moved[DATA_W+1] ? W_MIN : W_MAX;
      end

      step_mem[idx]   = step;
      sign_mem[idx]   = (kind == UPD_SHRINK) ? SIGN_ZERO : grad_code;
      entry_live[idx] = 1'b1;
      return result;
   endfunction

   // Check every result beat against the oldest owed weight.
   always @(posedge clock) begin : check_result
      logic signed [DATA_W-1:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (new_weight_q.size() == 0) begin
            $error("unexpected result beat: new_weight actual %0d", rsp_new_weight);
            fail_cnt++;
         end else begin
            want = new_weight_q.pop_front();
            if (rsp_new_weight !== want) begin
               $error("new_weight mismatch: expected %0d, actual %0d", want, rsp_new_weight);
               fail_cnt++;
            end
         end
      end
   end

   // Stall the result channel in random bursts while idling is on.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ready  = 1'b0;
         stall_left = $urandom_range(0, 10);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // Offer one beat, maybe after a random gap, hold it until accepted, then predict it.
   task automatic send_update(input logic [IDX_W-1:0] idx,
                              input logic signed [DATA_W-1:0] grad,
                              input logic signed [DATA_W-1:0] w);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_param_index = idx;
      req_gradient    = grad;
      req_weight      = w;
      do @(posedge clock); while (req_ready !== 1'b1);
      new_weight_q.push_back(predict_weight(idx, grad, w));
   endtask

   // Drop valid and wait until every owed result is in and the write-back has settled.
   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (new_weight_q.size() != 0) @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wen = 1'b0;
      case (idx)
         CSR_ETA_PLUS:  eta_grow   = value[ETA_W-1:0];
         CSR_ETA_MINUS: eta_shrink = value[ETA_W-1:0];
         CSR_STEP_MAX:  step_cap   = value;
         CSR_STEP_MIN:  step_floor = value;
         CSR_STEP_INIT: step_start = value;
         default: ;
      endcase
   endtask

   // Rewrite all registers once the block has gone quiet.
   task automatic load_settings(input logic [ETA_W-1:0] ep, input logic [ETA_W-1:0] em,
                                input logic [DATA_W-1:0] smax, input logic [DATA_W-1:0] smin,
                                input logic [DATA_W-1:0] sinit);
      drain();
      write_csr(CSR_ETA_PLUS, DATA_W'(ep));
      write_csr(CSR_ETA_MINUS, DATA_W'(em));
      write_csr(CSR_STEP_MAX, smax);
      write_csr(CSR_STEP_MIN, smin);
      write_csr(CSR_STEP_INIT, sinit);
   endtask

   // Mostly steady-signed gradients on a few hot indexes, so steps grow, shrink and cap;
   // the rest is fully random noise across the whole index range.
   task automatic send_random_update(input int unsigned hot_count);
      int unsigned              k;
      logic [DATA_W-1:0]        mag;
      logic signed [DATA_W-1:0] grad;
      logic signed [DATA_W-1:0] w;
      w = $urandom;
      if ($urandom_range(0, 7) == 0)
         w = $urandom_range(0, 1) ? W_MAX - $urandom_range(0, 32'h0004_0000)
                                  : W_MIN + $urandom_range(0, 32'h0004_0000);
      if ($urandom_range(0, 4) == 0) begin
         send_update(IDX_W'($urandom), $urandom, w);
      end else begin
         k = $urandom_range(0, hot_count - 1);
         if ($urandom_range(0, 4) == 0) hot_neg[k] = ~hot_neg[k];
         mag = $urandom_range(0, 1) ? $urandom_range(1, 32'h0010_0000)
                                    : $urandom_range(1, 32'h7FFF_FFFF);
         case ($urandom_range(0, 11))
            0:       grad = '0;
            1:       grad = hot_neg[k] ? W_MIN : W_MAX;
            default: grad = hot_neg[k] ? -$signed(mag) : $signed(mag);
         endcase
         send_update(hot_idx[k], grad, w);
      end
   endtask

   // Reset settings, back to back: first touch, grow, shrink, hold, zero gradient,
   // saturation both ways, extreme indexes and gradients, same-index hazards.
   task automatic test_directed_updates;
      idle_on = 1'b0;
      send_update(10'd0, ONE, 32'sd0);
      send_update(10'd0, 32'sh0040_0000, 32'sh0005_0000);
      send_update(10'd0, 32'sd1, 32'sh0005_0000);
      send_update(10'd0, MINUS1, 32'sh0005_0000);
      send_update(10'd0, MINUS1, -32'sh0003_0000);
      send_update(10'd0, 32'sd0, 32'sd0);
      send_update(10'd0, W_MIN, 32'sh7FFF_FFF0);
      send_update(10'd0, W_MIN, 32'sh7FFF_FFF0);
      send_update(10'd1023, W_MAX, W_MIN);
      send_update(10'd1023, -32'sd1, W_MIN);
      send_update(10'd1023, 32'sd1, W_MAX);
      send_update(10'd1023, 32'sd1, W_MAX);
      send_update(10'd1023, 32'sd0, 32'sd1);
      send_update(10'd1023, -32'sd1, -32'sd1);
      send_update(10'h155, 32'shAAAA_5555, 32'sh5555_AAAA);
      send_update(10'h2AA, 32'sh5555_AAAA, 32'shAAAA_5555);
   endtask

   // Extreme register values: saturating step products, zero etas, crossed bounds.
   task automatic test_step_extremes;
      load_settings('1, '1, '1, '0, '1);
      send_update(10'd3, ONE, 32'sd0);
      send_update(10'd3, ONE, 32'sd0);
      send_update(10'd3, MINUS1, 32'sd7);
      send_update(10'd3, MINUS1, W_MAX);
      load_settings('0, '0, '0, '1, '0);
      send_update(10'd4, ONE, 32'sd5);
      send_update(10'd4, ONE, 32'sd5);
      send_update(10'd4, MINUS1, 32'sd5);
      send_update(10'd4, MINUS1, W_MAX);
      send_update(10'd4, MINUS1, 32'sd0);
   endtask

   // Several random settings, each with its own hot indexes; idling off in one phase.
   task automatic test_random_updates;
      logic [ETA_W-1:0]  ep, em;
      logic [DATA_W-1:0] smax, smin, sinit;
      for (int phase = 0; phase < 5; phase++) begin
         ep    = ($urandom_range(0, 5) == 0) ? ETA_W'($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                             : ETA_W'($urandom_range(16400, 26000));
         em    = ($urandom_range(0, 5) == 0) ? ETA_W'($urandom)
                                             : ETA_W'($urandom_range(2000, 14000));
         smax  = ($urandom_range(0, 5) == 0) ? '1 : $urandom_range(32'h0001_0000, 32'h0100_0000);
         smin  = ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(1, 32'h0000_0400);
         sinit = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 32'h0004_0000);
         load_settings(ep, em, smax, smin, sinit);
         idle_on = (phase != 2);
         foreach (hot_idx[k]) hot_idx[k] = IDX_W'($urandom);
         repeat (70) send_random_update(HOT_COUNT);
      end
   endtask

   // Full rate with no idling on either side, few indexes so hazards stack up.
   task automatic test_full_rate;
      load_settings(ETA_PLUS_RST, ETA_MINUS_RST, STEP_MAX_RST, STEP_MIN_RST, STEP_INIT_RST);
      idle_on = 1'b0;
      foreach (hot_idx[k]) hot_idx[k] = IDX_W'($urandom);
      repeat (60) send_random_update(3);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_updates();
      test_step_extremes();
      test_random_updates();
      test_full_rate();

      // Let any stray beat show up before the verdict.
      drain();
      repeat (PIPE_SLACK) @(posedge clock);
      if (fail_cnt == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Bail out if the run hangs.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
